/* hw/rtl/sha1_pkg.sv */
package sha1_pkg;

  localparam int WORDS      = 5;
  localparam int ROUNDS     = 80;
  localparam int PHASE_LEN  = 20;
  localparam int ROUND_W    = $clog2(ROUNDS);
  localparam int FILL_W     = 6;
  localparam int SCHED_LEN  = 16;

  // initial chaining words, word 0 in the low slot
  localparam logic [WORDS-1:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [7:0]        PAD_MARK  = 8'h80;
  localparam logic [FILL_W-1:0] LEN_START = 6'd56;
  localparam logic [2:0]        LAST_IDX  = 3'(WORDS - 1);

  // source of the byte pushed into the block
  typedef logic [1:0] byte_sel_t;
  localparam byte_sel_t SEL_IN   = 2'd0;
  localparam byte_sel_t SEL_MARK = 2'd1;
  localparam byte_sel_t SEL_ZERO = 2'd2;
  localparam byte_sel_t SEL_LEN  = 2'd3;

  // round function groups
  typedef logic [1:0] phase_t;
  localparam phase_t PH_CH   = 2'd0;
  localparam phase_t PH_PAR1 = 2'd1;
  localparam phase_t PH_MAJ  = 2'd2;
  localparam phase_t PH_PAR2 = 2'd3;

  typedef struct packed {
    logic      push;
    byte_sel_t sel;
    logic      count_inc;
    logic      load_work;
    logic      round;
    phase_t    phase;
    logic      add_chain;
    logic      finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              out_busy;
  } dp_stat_t;

  function automatic logic [31:0] round_k(input phase_t ph);
    logic [31:0] k;
    case (ph)
      PH_CH:   k = 32'h5A827999;
      PH_PAR1: k = 32'h6ED9EBA1;
      PH_MAJ:  k = 32'h8F1BBCDC;
      PH_PAR2: k = 32'hCA62C1D6;
      default: k = 32'h5A827999;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/sha1_byte_stream_hash_core.sv */
// sha-1 hash over a byte stream
// input channel (in_valid/in_ready): one request per cycle at most, carrying
//   has_byte, data_byte and end_of_message; a request with has_byte low and
//   end_of_message high closes the message with no byte (empty message ok)
// output channel (out_valid/out_ready): five requests per closed message,
//   digest_word 0 (most significant) first, word_index 0..4, last_word on 4
// compression: every 64th byte starts 80 rounds of one shared round unit
//   followed by one chaining add; no input is accepted until it is done
// after the closing request, padding pushes one byte per cycle up to the
//   block end, each padded block (one or two) is compressed, then the digest
//   is loaded into the output register; the first word appears after that
// the digest sits in its own output register, so a stalled receiver does not
//   block input; only a second digest finishing while the first is still
//   unsent waits for the output register to drain
// reset (rst, synchronous) loads the initial chaining words and clears
//   fill level, byte count and output valid; no clearing pass is needed
module sha1_byte_stream_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        has_byte,
  input  logic [7:0]  data_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1_pkg::*;

  // commands from the sequencer, fill level and output status back
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: byte intake, padding walk, round counting, digest hand-off
  sha1_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .in_ready       (in_ready),
    .stat           (stat),
    .cmd            (cmd)
  );

  // datapath: schedule shift line, round unit, chaining words, output register
  sha1_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule

/* hw/rtl/sha1_dp.sv */
module sha1_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        data_byte,
  input  sha1_pkg::dp_cmd_t cmd,
  output sha1_pkg::dp_stat_t stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index,
  output logic              last_word
);
  import sha1_pkg::*;

  logic [WORDS-1:0][31:0]     chain;
  logic [FILL_W-1:0]          fill;
  logic [31:0]                count;
  logic [23:0]                acc;
  logic [SCHED_LEN-1:0][31:0] wline;
  logic [31:0]                a, b, c, d, e;
  logic [WORDS-1:0][31:0]     dout;
  logic [2:0]                 oidx;
  logic                       ovalid;

  logic [7:0]  pbyte;
  logic [31:0] bits;
  logic [31:0] f;
  logic [31:0] t;
  logic [31:0] new_w;
  logic        out_take;

  assign bits     = {count[28:0], 3'b000};
  assign out_take = ovalid && out_ready;

  always_comb begin
    case (cmd.sel)
      SEL_IN:   pbyte = data_byte;
      SEL_MARK: pbyte = PAD_MARK;
      SEL_ZERO: pbyte = 8'h00;
      SEL_LEN: begin
        case (fill[1:0])
          2'd0:    pbyte = bits[31:24];
          2'd1:    pbyte = bits[23:16];
          2'd2:    pbyte = bits[15:8];
          2'd3:    pbyte = bits[7:0];
          default: pbyte = 8'h00;
        endcase
      end
      default:  pbyte = 8'h00;
    endcase
  end

  always_comb begin
    case (cmd.phase)
      PH_CH:   f = (b & c) | (~b & d);
      PH_MAJ:  f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
  end

  assign t = {a[26:0], a[31:27]} + f + e + round_k(cmd.phase) + wline[0];

  logic [31:0] sched_x;
  assign sched_x = wline[13] ^ wline[8] ^ wline[2] ^ wline[0];
  assign new_w   = {sched_x[30:0], sched_x[31]};

  // control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      chain  <= H_INIT;
      fill   <= '0;
      count  <= '0;
      ovalid <= 1'b0;
      oidx   <= '0;
    end else begin
      if (cmd.push) begin
        fill <= fill + 1'b1;
      end
      if (cmd.count_inc) begin
        count <= count + 32'd1;
      end
      if (cmd.add_chain) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
      if (out_take) begin
        oidx <= oidx + 3'd1;
        if (oidx == LAST_IDX) begin
          ovalid <= 1'b0;
        end
      end
      if (cmd.finish) begin
        chain  <= H_INIT;
        fill   <= '0;
        count  <= '0;
        ovalid <= 1'b1;
        oidx   <= '0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      acc <= {acc[15:0], pbyte};
    end
    if (cmd.push && fill[1:0] == 2'd3) begin
      wline <= {{acc, pbyte}, wline[SCHED_LEN-1:1]};
    end else if (cmd.round) begin
      wline <= {new_w, wline[SCHED_LEN-1:1]};
    end
    if (cmd.load_work) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (cmd.round) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
    if (cmd.finish) begin
      dout <= chain;
    end else if (out_take) begin
      dout <= dout >> 32;
    end
  end

  assign stat.fill     = fill;
  assign stat.out_busy = ovalid;
  assign out_valid     = ovalid;
  assign digest_word   = dout[0];
  assign word_index    = oidx;
  assign last_word     = (oidx == LAST_IDX);

  a_finish_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (fill == '0) && (count == '0) && ovalid && (oidx == '0))
    else $error("message state not restarted after digest load");

  a_last_word_ends: assert property (@(posedge clk) disable iff (rst)
    (out_take && oidx == LAST_IDX && !cmd.finish) |=> !ovalid)
    else $error("output still valid after last digest word");

endmodule

/* hw/rtl/sha1_ctrl.sv */
module sha1_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               has_byte,
  input  logic               end_of_message,
  output logic               in_ready,
  input  sha1_pkg::dp_stat_t stat,
  output sha1_pkg::dp_cmd_t  cmd
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MARK  = 3'd1;
  localparam logic [2:0] S_PAD   = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]         state, state_next;
  logic [2:0]         ret, ret_next;
  logic [ROUND_W-1:0] rcnt, rcnt_next;
  logic               len_phase, len_phase_next;

  logic   full;
  logic   lp;
  phase_t phase;

  assign full = (stat.fill == '1);
  assign lp   = len_phase || (stat.fill == LEN_START);

  always_comb begin
    if (rcnt < ROUND_W'(PHASE_LEN)) begin
      phase = PH_CH;
    end else if (rcnt < ROUND_W'(2 * PHASE_LEN)) begin
      phase = PH_PAR1;
    end else if (rcnt < ROUND_W'(3 * PHASE_LEN)) begin
      phase = PH_MAJ;
    end else begin
      phase = PH_PAR2;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.phase      = phase;
    state_next     = state;
    ret_next       = ret;
    rcnt_next      = rcnt;
    len_phase_next = len_phase;
    in_ready       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (has_byte) begin
            cmd.push      = 1'b1;
            cmd.sel       = SEL_IN;
            cmd.count_inc = 1'b1;
          end
          if (has_byte && full) begin
            cmd.load_work = 1'b1;
            rcnt_next     = '0;
            ret_next      = end_of_message ? S_MARK : S_IDLE;
            state_next    = S_ROUND;
          end else if (end_of_message) begin
            state_next = S_MARK;
          end
        end
      end
      S_MARK: begin
        cmd.push       = 1'b1;
        cmd.sel        = SEL_MARK;
        len_phase_next = 1'b0;
        if (full) begin
          cmd.load_work = 1'b1;
          rcnt_next     = '0;
          ret_next      = S_PAD;
          state_next    = S_ROUND;
        end else begin
          state_next = S_PAD;
        end
      end
      S_PAD: begin
        cmd.push       = 1'b1;
        cmd.sel        = (lp && stat.fill[5:2] == 4'hF) ? SEL_LEN : SEL_ZERO;
        len_phase_next = lp;
        if (full) begin
          cmd.load_work = 1'b1;
          rcnt_next     = '0;
          ret_next      = lp ? S_DONE : S_PAD;
          state_next    = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rcnt_next = rcnt + 1'b1;
        if (rcnt == ROUND_W'(ROUNDS - 1)) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
        state_next    = ret;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      rcnt      <= '0;
      len_phase <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      rcnt      <= rcnt_next;
      len_phase <= len_phase_next;
    end
  end

  a_load_on_full: assert property (@(posedge clk) disable iff (rst)
    cmd.load_work |-> cmd.push && full)
    else $error("compression started on a partial block");

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rcnt == ROUND_W'(ROUNDS - 1)) |=> state == S_ADD)
    else $error("round count overran");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !stat.out_busy)
    else $error("digest loaded over a pending one");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> rcnt < ROUND_W'(ROUNDS))
    else $error("round counter out of range");

endmodule
